// ===== design/rau_pkg.sv =====
`timescale 1ns / 1ps

package rau_pkg;

	// Operation codes carried in req_type.
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	// Stream widths.
	localparam int unsigned S_DATA_W = 136;
	localparam int unsigned M_DATA_W = 72;

	// Sequencer states, one-hot.
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_MUL  = 8'b0000_0010,
		S_FORM = 8'b0000_0100,
		S_GSH  = 8'b0000_1000,
		S_GLP  = 8'b0001_0000,
		S_DIVN = 8'b0010_0000,
		S_DIVD = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

endpackage

// ===== design/rational_arith_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Contents
// s_*      | in        | s_tvalid/s_tready  | req_type, a_num, a_den, b_num, b_den
// m_*      | out       | m_tvalid/m_tready  | res_num, res_den, status, less_than, equal
//
// An item passes through the multiply steps, the forming of numerator and denominator,
// a binary gcd and two restoring divisions.
// An item with a zero denominator goes from idle straight to the final state.
// The multiplier is shared by the products, the subtract-and-compare unit by the divisions.
// s_tready is high only while the sequencer is idle; a new item may be taken while
// the previous result still waits in the output register.
// The asynchronous reset clears the sequencer and the output valid flag only.

module rational_arith_unit #(
	parameter int unsigned OPERAND_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// From bit 0: req_type[1:0], a_num[31:0], a_den[31:0], b_num[31:0], b_den[31:0], zeros.
	input  logic [rau_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// From bit 0: res_num[31:0], res_den[30:0], status[1:0], less_than, equal, zeros.
	output logic [rau_pkg::M_DATA_W-1:0]  m_tdata
);

	// Product width, and sum width with one carry bit.
	localparam int unsigned W   = OPERAND_WIDTH;
	localparam int unsigned PRW = 2 * W;
	localparam int unsigned PW  = 2 * W + 1;
	localparam int unsigned CW  = $clog2(PW);
	localparam logic [CW-1:0] CNT_LAST = CW'(PW - 1);
	localparam logic [PW-1:0] HALF = PW'(1) << (W - 1);

	rau_pkg::state_t state_q;

	// Operand signs and magnitudes captured at acceptance.
	logic [1:0]   op_q;
	logic         an_n_q, ad_n_q, bn_n_q, bd_n_q;
	logic [W-1:0] anm_q, adm_q, bnm_q, bdm_q;

	logic [1:0]     mcnt_q;
	logic [PRW-1:0] p1_q, p2_q, p3_q, p4_q;

	logic          nneg_q, dneg_q;
	logic [PW-1:0] x_q, y_q, nr_q, dr_q;
	logic [PW:0]   rem_q;
	logic [PW-1:0] quo_q, nq_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    st_q;
	logic          lt_q, eq_q;

	// Field extraction from the input item.
	logic [1:0]   in_op;
	logic [W-1:0] in_an, in_ad, in_bn, in_bd;

	assign in_op = s_tdata[1:0];
	assign in_an = s_tdata[2 +: W];
	assign in_ad = s_tdata[34 +: W];
	assign in_bn = s_tdata[66 +: W];
	assign in_bd = s_tdata[98 +: W];

	assign s_tready = (state_q == rau_pkg::S_IDLE);

	// The single shared multiplier: one product per cycle.
	logic [W-1:0]   mul_a, mul_b;
	logic [PRW-1:0] mul_p;

	always_comb begin
		unique case (mcnt_q)
			2'd0: begin mul_a = anm_q; mul_b = bdm_q; end
			2'd1: begin mul_a = bnm_q; mul_b = adm_q; end
			2'd2: begin mul_a = adm_q; mul_b = bdm_q; end
			default: begin mul_a = anm_q; mul_b = bnm_q; end
		endcase
		mul_p = PRW'(mul_a) * PRW'(mul_b);
	end

	// Forming the exact numerator and denominator, and the operand comparison.
	logic          t1n, t2n, f_nneg, f_dneg;
	logic [PW-1:0] m1, m2, f_nmag, f_dmag;
	logic [PW-1:0] lv, rv;

	always_comb begin
		m1 = PW'(p1_q);
		m2 = PW'(p2_q);
		t1n = an_n_q ^ bd_n_q;
		t2n = bn_n_q ^ ad_n_q ^ (op_q == rau_pkg::OP_SUB);
		f_nneg = t1n;
		f_nmag = m1;
		f_dneg = ad_n_q ^ bd_n_q;
		f_dmag = PW'(p3_q);
		unique case (op_q)
			rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
				if (t1n == t2n) begin
					f_nmag = m1 + m2;
				end else if (m1 >= m2) begin
					f_nmag = m1 - m2;
				end else begin
					f_nneg = t2n;
					f_nmag = m2 - m1;
				end
			end
			rau_pkg::OP_MUL: begin
				f_nneg = an_n_q ^ bn_n_q;
				f_nmag = PW'(p4_q);
			end
			default: begin
				f_dneg = ad_n_q ^ bn_n_q;
				f_dmag = m2;
			end
		endcase
		// Cross products with the denominator signs moved into the numerators.
		lv = (an_n_q ^ ad_n_q) ? (PW'(0) - m1) : m1;
		rv = (bn_n_q ^ bd_n_q) ? (PW'(0) - m2) : m2;
	end

	// Restoring division step on the shared subtractor.
	logic [PW:0]   d_t;
	logic          d_ge;
	logic [PW-1:0] d_quo;
	logic [PW:0]   d_rem;

	always_comb begin
		d_t = {rem_q[PW-1:0], quo_q[PW-1]};
		d_ge = (d_t >= {1'b0, x_q});
		d_rem = d_ge ? (d_t - {1'b0, x_q}) : d_t;
		d_quo = {quo_q[PW-2:0], d_ge};
	end

	// Final range check on the reduced fraction.
	logic          f_neg, f_ovf;
	logic [PW-1:0] f_num;

	always_comb begin
		f_neg = (nneg_q ^ dneg_q) && (nq_q != '0);
		f_ovf = (quo_q > HALF - PW'(1)) ||
			(nq_q > (f_neg ? HALF : HALF - PW'(1)));
		f_num = f_neg ? (PW'(0) - nq_q) : nq_q;
	end

	logic out_free;
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rau_pkg::S_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			// In the final state a taken result is replaced by the new one below.
			if (m_tvalid && m_tready && state_q != rau_pkg::S_FIN) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				rau_pkg::S_IDLE: begin
					if (s_tvalid) begin
						state_q <= (in_ad == '0 || in_bd == '0) ? rau_pkg::S_FIN
							: rau_pkg::S_MUL;
					end
				end
				rau_pkg::S_MUL: begin
					if (mcnt_q == 2'd3) begin
						state_q <= rau_pkg::S_FORM;
					end
				end
				rau_pkg::S_FORM: begin
					state_q <= (f_dmag == '0) ? rau_pkg::S_FIN : rau_pkg::S_GSH;
				end
				rau_pkg::S_GSH: begin
					if (x_q == '0 || x_q[0] || y_q[0]) begin
						state_q <= rau_pkg::S_GLP;
					end
				end
				rau_pkg::S_GLP: begin
					if (y_q == '0) begin
						state_q <= rau_pkg::S_DIVN;
					end
				end
				rau_pkg::S_DIVN: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= rau_pkg::S_DIVD;
					end
				end
				rau_pkg::S_DIVD: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= rau_pkg::S_FIN;
					end
				end
				default: begin
					if (out_free) begin
						state_q  <= rau_pkg::S_IDLE;
						m_tvalid <= 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			rau_pkg::S_IDLE: begin
				op_q   <= in_op;
				an_n_q <= in_an[W-1];
				ad_n_q <= in_ad[W-1];
				bn_n_q <= in_bn[W-1];
				bd_n_q <= in_bd[W-1];
				anm_q  <= in_an[W-1] ? (W'(0) - in_an) : in_an;
				adm_q  <= in_ad[W-1] ? (W'(0) - in_ad) : in_ad;
				bnm_q  <= in_bn[W-1] ? (W'(0) - in_bn) : in_bn;
				bdm_q  <= in_bd[W-1] ? (W'(0) - in_bd) : in_bd;
				mcnt_q <= 2'd0;
				st_q   <= rau_pkg::ST_ZERO;
				lt_q   <= 1'b0;
				eq_q   <= 1'b0;
			end
			rau_pkg::S_MUL: begin
				unique case (mcnt_q)
					2'd0: p1_q <= mul_p;
					2'd1: p2_q <= mul_p;
					2'd2: p3_q <= mul_p;
					default: p4_q <= mul_p;
				endcase
				mcnt_q <= mcnt_q + 2'd1;
			end
			rau_pkg::S_FORM: begin
				nneg_q <= f_nneg;
				dneg_q <= f_dneg;
				x_q    <= f_nmag;
				y_q    <= f_dmag;
				nr_q   <= f_nmag;
				dr_q   <= f_dmag;
				st_q   <= (f_dmag == '0) ? rau_pkg::ST_ZERO : rau_pkg::ST_OK;
				lt_q   <= $signed(lv) < $signed(rv);
				eq_q   <= (lv == rv);
			end
			rau_pkg::S_GSH: begin
				// Strip common factors of two from both terms and the copies.
				// A zero numerator is reduced straight to zero over one.
				if (x_q == '0) begin
					x_q <= PW'(1);
					y_q <= '0;
					nr_q <= '0;
					dr_q <= PW'(1);
				end else if (!x_q[0] && !y_q[0]) begin
					x_q  <= x_q >> 1;
					y_q  <= y_q >> 1;
					nr_q <= nr_q >> 1;
					dr_q <= dr_q >> 1;
				end
			end
			rau_pkg::S_GLP: begin
				if (y_q == '0) begin
					quo_q <= nr_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q > y_q) begin
					x_q <= y_q;
					y_q <= x_q - y_q;
				end else begin
					y_q <= y_q - x_q;
				end
			end
			rau_pkg::S_DIVN: begin
				if (cnt_q == CNT_LAST) begin
					nq_q  <= d_quo;
					quo_q <= dr_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + CW'(1);
					quo_q <= d_quo;
					rem_q <= d_rem;
				end
			end
			rau_pkg::S_DIVD: begin
				cnt_q <= cnt_q + CW'(1);
				quo_q <= d_quo;
				rem_q <= d_rem;
			end
			default: begin
				if (out_free) begin
					if (st_q != rau_pkg::ST_OK) begin
						m_tdata <= {{(rau_pkg::M_DATA_W - 67){1'b0}}, eq_q, lt_q, st_q,
							31'd0, 32'd0};
					end else if (f_ovf) begin
						m_tdata <= {{(rau_pkg::M_DATA_W - 67){1'b0}}, eq_q, lt_q,
							rau_pkg::ST_OVF, 31'd0, 32'd0};
					end else begin
						m_tdata <= {{(rau_pkg::M_DATA_W - 67){1'b0}}, eq_q, lt_q,
							rau_pkg::ST_OK, 31'(quo_q[W-2:0]),
							32'($signed(f_num[W-1:0]))};
					end
				end
			end
		endcase
	end

endmodule

// ===== design/rau_chk.sv =====
`timescale 1ns / 1ps

module rau_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [rau_pkg::M_DATA_W-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[64:63] != 2'd3)
		else $error("status code out of range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[64:63] != rau_pkg::ST_OK |->
		m_tdata[31:0] == 32'd0 && m_tdata[62:32] == 31'd0)
		else $error("fraction not cleared on error status");

	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[64:63] == rau_pkg::ST_OK |-> m_tdata[62:32] != 31'd0)
		else $error("zero denominator with ok status");

	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[65] && m_tdata[66]))
		else $error("less_than and equal both set");

endmodule

bind rational_arith_unit rau_chk u_rau_chk (.*);

// ===== tb/rational_arith_unit_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the rational arithmetic unit.
// Requests are queued up front, a burst-mode driver feeds them into the slave stream, and a
// monitor compares every result item against an independent fraction predictor.
module rational_arith_unit_tb;

	localparam int unsigned OPW        = 32;
	localparam int unsigned N_RANDOM   = 1900;
	localparam int unsigned DRAIN_CYC  = 600;
	localparam int unsigned HOLD_CYC   = 4000;
	localparam int unsigned HOLD_AFTER = 200;

	// One result item as the block should present it.
	typedef struct packed {
		logic        equal;
		logic        less_than;
		logic [1:0]  status;
		logic [30:0] res_den;
		logic [31:0] res_num;
	} fraction_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	// From bit 0: req_type[1:0], a_num[31:0], a_den[31:0], b_num[31:0], b_den[31:0], zeros.
	logic [rau_pkg::S_DATA_W-1:0]  s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	// From bit 0: res_num[31:0], res_den[30:0], status[1:0], less_than, equal, zeros.
	logic [rau_pkg::M_DATA_W-1:0]  m_tdata;

	logic [rau_pkg::S_DATA_W-1:0]  pending_reqs[$];
	fraction_result_t              expected_results[$];
	int unsigned                   error_count = 0;
	int unsigned                   results_seen = 0;
	int unsigned                   op_seen[4];
	int unsigned                   status_seen[4];

	rational_arith_unit #(.OPERAND_WIDTH(OPW)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Magnitude of a signed 64-bit quantity as an unsigned value.
	function automatic logic [63:0] magnitude(longint signed v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	// Works out the reduced fraction, status and comparison flags for one request.
	// Intermediates are kept as sign and magnitude; every product fits 63 bits.
	function automatic fraction_result_t predict_fraction(logic [rau_pkg::S_DATA_W-1:0] req);
		fraction_result_t r;
		logic [1:0]       op;
		longint signed    an, ad, bn, bd, na, nb, lhs, rhs;
		logic [63:0]      anm, adm, bnm, bdm, t1, t2, nmag, dmag, g, x, y, rem;
		logic [63:0]      half;
		logic             nneg, dneg, t1n, t2n, neg;
		op   = req[1:0];
		an   = longint'($signed(req[33:2]));
		ad   = longint'($signed(req[65:34]));
		bn   = longint'($signed(req[97:66]));
		bd   = longint'($signed(req[129:98]));
		half = 64'd1 << (OPW - 1);
		r    = '0;
		r.status = rau_pkg::ST_OK;
		// Either operand without a value: no comparison at all.
		if (ad == 0 || bd == 0) begin
			r.status = rau_pkg::ST_ZERO;
			return r;
		end
		// Compare by cross-multiplying, with denominator signs moved up.
		na  = ad < 0 ? -an : an;
		nb  = bd < 0 ? -bn : bn;
		lhs = na * longint'(magnitude(bd));
		rhs = nb * longint'(magnitude(ad));
		r.less_than = lhs < rhs;
		r.equal     = lhs == rhs;

		anm = magnitude(an);
		adm = magnitude(ad);
		bnm = magnitude(bn);
		bdm = magnitude(bd);
		case (op)
			rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
				t1n = (an < 0) != (bd < 0);
				t2n = (bn < 0) != (ad < 0);
				if (op == rau_pkg::OP_SUB)
					t2n = !t2n;
				t1 = anm * bdm;
				t2 = bnm * adm;
				if (t1n == t2n) begin
					nneg = t1n;
					nmag = t1 + t2;
				end else if (t1 >= t2) begin
					nneg = t1n;
					nmag = t1 - t2;
				end else begin
					nneg = t2n;
					nmag = t2 - t1;
				end
				dneg = (ad < 0) != (bd < 0);
				dmag = adm * bdm;
			end
			rau_pkg::OP_MUL: begin
				nneg = (an < 0) != (bn < 0);
				nmag = anm * bnm;
				dneg = (ad < 0) != (bd < 0);
				dmag = adm * bdm;
			end
			default: begin
				nneg = (an < 0) != (bd < 0);
				nmag = anm * bdm;
				dneg = (ad < 0) != (bn < 0);
				dmag = adm * bnm;
			end
		endcase

		// Dividing by a zero numerator leaves a zero denominator.
		if (dmag == 0) begin
			r.status = rau_pkg::ST_ZERO;
			return r;
		end
		x = nmag;
		y = dmag;
		while (y != 0) begin
			rem = x % y;
			x   = y;
			y   = rem;
		end
		g    = x;
		nmag = nmag / g;
		dmag = dmag / g;
		neg  = (nneg != dneg) && nmag != 0;
		if (dmag > half - 1 || nmag > (neg ? half : half - 1)) begin
			r.status = rau_pkg::ST_OVF;
		end else begin
			r.res_num = neg ? 32'(64'd0 - nmag) : nmag[31:0];
			r.res_den = dmag[30:0];
		end
		return r;
	endfunction

	function automatic logic [rau_pkg::S_DATA_W-1:0] pack_request(logic [1:0] op, int an,
			int ad, int bn, int bd);
		logic [rau_pkg::S_DATA_W-1:0] d;
		d = '0;
		d[1:0]    = op;
		d[33:2]   = an;
		d[65:34]  = ad;
		d[97:66]  = bn;
		d[129:98] = bd;
		return d;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		error_count++;
		$display("[%0t] mismatch on %s in result %0d: got %0d, expected %0d",
			$time, field, results_seen, got, want);
	endtask

	// Driver: bursts of random length, with random gaps between them. Valid is only
	// reconsidered once the item on the bus has been taken or none is offered.
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	always @(posedge clk) begin
		logic                          next_valid;
		logic [rau_pkg::S_DATA_W-1:0]  next_data;
		next_valid = s_tvalid;
		next_data  = s_tdata;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(predict_fraction(pending_reqs[0]));
				op_seen[pending_reqs[0][1:0]]++;
				void'(pending_reqs.pop_front());
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					next_valid = 1'b0;
				end else if (pending_reqs.size() > 0) begin
					next_valid = 1'b1;
					next_data  = pending_reqs[0];
				end else begin
					next_valid = 1'b0;
				end
			end
		end
		s_tvalid <= next_valid;
		s_tdata  <= next_data;
	end

	// Receiver: stretches of full readiness alternate with random stalls, and once in the
	// run it holds off for a long stretch so that the block backs up to its input.
	int unsigned cycle_count = 0;
	int unsigned hold_left = 0;
	logic        long_hold_done = 1'b0;
	always @(posedge clk) begin
		logic next_ready;
		cycle_count++;
		if (!arst_n) begin
			next_ready = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			next_ready = 1'b0;
		end else if (!long_hold_done && results_seen == HOLD_AFTER) begin
			long_hold_done = 1'b1;
			hold_left      = HOLD_CYC;
			next_ready     = 1'b0;
		end else if (cycle_count[9]) begin
			next_ready = 1'b1;
		end else begin
			next_ready = ($urandom_range(0, 3) != 0);
		end
		m_tready <= next_ready;
	end

	// Monitor: every accepted result is checked against the oldest expectation.
	always @(posedge clk) begin
		fraction_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[66:0];
			if (expected_results.size() == 0) begin
				error_count++;
				$display("[%0t] result item with no request outstanding", $time);
			end else begin
				want = expected_results.pop_front();
				status_seen[want.status]++;
				if (got.res_num !== want.res_num)
					report_mismatch("res_num", $signed(got.res_num), $signed(want.res_num));
				if (got.res_den !== want.res_den)
					report_mismatch("res_den", got.res_den, want.res_den);
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.less_than !== want.less_than)
					report_mismatch("less_than", got.less_than, want.less_than);
				if (got.equal !== want.equal)
					report_mismatch("equal", got.equal, want.equal);
			end
			results_seen++;
		end
	end

	// Random signed value in a small range, used for most operands.
	function automatic int small_value(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic int nonzero_small(int span);
		int v;
		v = small_value(span);
		return v == 0 ? 1 : v;
	endfunction

	// Stimulus: a short directed set, then random requests of several shapes.
	initial begin
		int          an, ad, bn, bd, kind;
		logic [1:0]  op;
		// Extremes and every operation.
		for (int o = 0; o < 4; o++) begin
			pending_reqs.push_back(pack_request(2'(o), 32'h7fffffff, 1, 32'h7fffffff, 1));
			pending_reqs.push_back(pack_request(2'(o), 32'h80000000, 32'h80000000,
				32'h80000000, 32'h7fffffff));
			pending_reqs.push_back(pack_request(2'(o), 3, -4, -5, -6));
		end
		// Zero denominators in either operand.
		pending_reqs.push_back(pack_request(rau_pkg::OP_ADD, 1, 0, 2, 3));
		pending_reqs.push_back(pack_request(rau_pkg::OP_MUL, 1, 2, 3, 0));
		// Division by a zero numerator, with the flags still compared.
		pending_reqs.push_back(pack_request(rau_pkg::OP_DIV, -7, 3, 0, 5));
		// Zero results come out as zero over one.
		pending_reqs.push_back(pack_request(rau_pkg::OP_SUB, 5, 7, 10, 14));
		pending_reqs.push_back(pack_request(rau_pkg::OP_MUL, 0, -9, 4, 3));
		// Overflow in the numerator, in the denominator, and negating the minimum.
		pending_reqs.push_back(pack_request(rau_pkg::OP_ADD, 32'h7fffffff, 1, 1, 1));
		pending_reqs.push_back(pack_request(rau_pkg::OP_MUL, 1, 65537, 1, 65539));
		pending_reqs.push_back(pack_request(rau_pkg::OP_DIV, 32'h80000000, 1, -1, 1));
		// Equal denominators must still add, and both-negative signs must cancel.
		pending_reqs.push_back(pack_request(rau_pkg::OP_ADD, 1, 6, 1, 6));
		pending_reqs.push_back(pack_request(rau_pkg::OP_SUB, -3, -8, -5, -8));
		pending_reqs.push_back(pack_request(rau_pkg::OP_DIV, 2, -3, 4, 5));

		for (int i = 0; i < N_RANDOM; i++) begin
			op   = 2'($urandom_range(0, 3));
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				an = small_value(1000);
				ad = nonzero_small(1000);
				bn = small_value(1000);
				bd = nonzero_small(1000);
			end else if (kind < 85) begin
				an = $urandom;
				ad = $urandom;
				bn = $urandom;
				bd = $urandom;
				if (ad == 0) ad = 1;
				if (bd == 0) bd = -1;
			end else if (kind < 90) begin
				an = $urandom;
				ad = ($urandom_range(0, 1) == 0) ? 0 : $urandom;
				bn = $urandom;
				bd = (ad != 0) ? 0 : $urandom;
			end else if (kind < 95) begin
				op = rau_pkg::OP_DIV;
				an = small_value(50000);
				ad = nonzero_small(50000);
				bn = 0;
				bd = $urandom;
				if (bd == 0) bd = 7;
			end else begin
				// Same value written two ways.
				an = small_value(3000);
				ad = nonzero_small(3000);
				kind = nonzero_small(50);
				bn = an * kind;
				bd = ad * kind;
			end
			pending_reqs.push_back(pack_request(op, an, ad, bn, bd));
		end
	end

	// Reset, then wait for the last result and a quiet tail before the verdict.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (pending_reqs.size() != 0 || expected_results.size() != 0);
		repeat (DRAIN_CYC) @(posedge clk);
		$display("Checked %0d results: add %0d, sub %0d, mul %0d, div %0d.",
			results_seen, op_seen[rau_pkg::OP_ADD], op_seen[rau_pkg::OP_SUB],
			op_seen[rau_pkg::OP_MUL], op_seen[rau_pkg::OP_DIV]);
		$display("Outcomes: %0d reduced, %0d without a value, %0d overflowed; %0d mismatches.",
			status_seen[rau_pkg::ST_OK], status_seen[rau_pkg::ST_ZERO],
			status_seen[rau_pkg::ST_OVF], error_count);
		if (error_count == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Run timed out with %0d results outstanding.", expected_results.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
design/rau_pkg.sv
design/rational_arith_unit.sv
design/rau_chk.sv
tb/rational_arith_unit_tb.sv
